### hdl/mlpq_pkg.sv
// ----------------------------------------------------------------------------
// mlpq_pkg: shared types and constants for the strict-priority queue
// Sizes, operation and status codes, controller states and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none
package mlpq_pkg;
  localparam int MaxLevels  = 10;
  localparam int LevelDepth = 16;
  localparam int LvW  = $clog2(MaxLevels);
  localparam int IdxW = $clog2(LevelDepth);
  localparam int CntW = $clog2(LevelDepth + 1);
  localparam int AddrW = $clog2(MaxLevels * LevelDepth);

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_ERASE   = 2'd2,
    OP_CONSUME = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHUP_RD,
    S_SHUP_WR,
    S_PLACE,
    S_SHDN_RD,
    S_SHDN_WR,
    S_FRONT_RD,
    S_FRONT_CHK,
    S_FOUND_RD,
    S_FOUND_CHK,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic rd_scan;    // read entry at scan index
    logic step_scan;  // advance scan index
    logic rd_up;      // read entry shift_idx-1
    logic wr_up;      // write read data to shift_idx, step down
    logic wr_new;     // write request position at scan index, or at the tail for push
    logic rd_dn;      // read entry shift_idx+1
    logic wr_dn;      // write read data to shift_idx, step up
    logic rd_front;   // read entry 0
    logic set_limit;  // compute search limit from front entry
    logic rd_found;   // read entry at scan index
    logic cnt_inc;
    logic cnt_dec;
    logic set_ok;
    logic set_nf;
    logic set_full;
    logic set_pop;    // latch read data as popped position
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic any_nonempty;
    logic level_full;
    logic level_empty;
    logic scan_more;  // entry before position
    logic scan_end;   // scan index reached limit
    logic up_done;    // shift index equals scan index
    logic dn_done;    // shift index+1 at or past count
    logic match;      // entry equals position
    logic at_in_range;
  } dp_sts_t;
endpackage
`default_nettype wire

### hdl/multi_level_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// multi_level_priority_queue_unit: strict-priority message queue
// Ten ordered position stores behind one controller and one datapath.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_stall carries one request: in_op (push,
//    release sorted insert, erase by position, consume highest level),
//    in_position and in_priority_req. A request is taken when in_valid is
//    high and in_stall low.
//  - Result channel out_valid/out_stall returns exactly one result per
//    request: out_status, out_position (popped value or zero), out_level.
//  - cfg_we/cfg_wdata set the number of levels in use; write only while idle.
//  - One request is worked at a time. Push passes through setup and place
//    before out_valid rises; release and erase walk the level entry by entry
//    through the store, a read state and a check state per scanned entry, and
//    consume shifts the level down entry by entry. After each retired result
//    the unit returns to idle, where the next request is taken.
//  - The store RAM port (one read, one write per cycle) paces these walks.
//  - Reset clears all level counts and sets ten levels; store contents are
//    not cleared, and data read past a count is never used.
//  - While out_stall is high the result is held and no request is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module multi_level_priority_queue_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [31:0] in_position,
  input  wire logic [7:0]  in_priority_req,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_position,
  output logic [3:0]       out_level,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata
);
  import mlpq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: owns both handshakes
  mlpq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .cmd, .sts
  );

  // datapath: store, counts, level map, result registers
  mlpq_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_op, .in_position, .in_priority_req,
    .cmd, .sts, .out_status, .out_position, .out_level
  );
endmodule
`default_nettype wire

### hdl/mlpq_ctrl.sv
// ----------------------------------------------------------------------------
// mlpq_ctrl: operation sequencer
// Steps each request through the scan, shift and count update that its operation needs.
// ----------------------------------------------------------------------------
`default_nettype none
module mlpq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output mlpq_pkg::dp_cmd_t     cmd,
  input  wire mlpq_pkg::dp_sts_t sts
);
  import mlpq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SETUP;
      S_SETUP: begin
        unique case (sts.op)
          OP_PUSH:    state_nxt = sts.level_full ? S_DONE : S_PLACE;
          OP_RELEASE: state_nxt = sts.level_full ? S_DONE : S_SCAN_RD;
          OP_ERASE:   state_nxt = sts.level_empty ? S_DONE : S_FRONT_RD;
          OP_CONSUME: state_nxt = sts.any_nonempty ? S_FRONT_RD : S_DONE;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_FRONT_RD:  state_nxt = S_FRONT_CHK;
      S_FRONT_CHK: state_nxt = (sts.op == OP_CONSUME) ? S_SHDN_RD : S_SCAN_RD;
      S_SCAN_RD:   state_nxt = sts.scan_end ? ((sts.op == OP_RELEASE) ? S_SHUP_RD : S_FOUND_RD)
                                            : S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (sts.scan_more) state_nxt = S_SCAN_RD;
        else state_nxt = (sts.op == OP_RELEASE) ? S_SHUP_RD : S_FOUND_RD;
      end
      S_SHUP_RD:   state_nxt = sts.up_done ? S_PLACE : S_SHUP_WR;
      S_SHUP_WR:   state_nxt = S_SHUP_RD;
      S_PLACE:     state_nxt = S_DONE;
      S_FOUND_RD:  state_nxt = sts.at_in_range ? S_FOUND_CHK : S_DONE;
      S_FOUND_CHK: state_nxt = sts.match ? S_SHDN_RD : S_DONE;
      S_SHDN_RD:   state_nxt = sts.dn_done ? S_DONE : S_SHDN_WR;
      S_SHDN_WR:   state_nxt = S_SHDN_RD;
      S_DONE:      if (!out_stall) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    out_valid = (state_r == S_DONE);
    unique case (state_r)
      S_IDLE:  cmd.load = in_valid;
      S_SETUP: begin
        cmd.set_ok = 1'b1;
        unique case (sts.op)
          OP_PUSH:    if (sts.level_full) cmd.set_full = 1'b1;
          OP_RELEASE: if (sts.level_full) cmd.set_full = 1'b1;
          OP_ERASE:   if (sts.level_empty) cmd.set_nf = 1'b1;
          OP_CONSUME: if (!sts.any_nonempty) cmd.set_nf = 1'b1;
          default: ;
        endcase
      end
      S_FRONT_RD:  cmd.rd_front = 1'b1;
      S_FRONT_CHK: begin
        if (sts.op == OP_CONSUME) cmd.set_pop = 1'b1;
        else cmd.set_limit = 1'b1;
      end
      S_SCAN_RD:   cmd.rd_scan = 1'b1;
      S_SCAN_CHK:  cmd.step_scan = sts.scan_more;
      S_SHUP_RD:   cmd.rd_up = !sts.up_done;
      S_SHUP_WR:   cmd.wr_up = 1'b1;
      S_PLACE: begin
        cmd.wr_new  = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      S_FOUND_RD: begin
        cmd.rd_found = 1'b1;
        cmd.set_nf   = !sts.at_in_range;
      end
      S_FOUND_CHK: cmd.set_nf = !sts.match;
      S_SHDN_RD: begin
        cmd.rd_dn   = !sts.dn_done;
        cmd.cnt_dec = sts.dn_done;
      end
      S_SHDN_WR:   cmd.wr_dn = 1'b1;
      default: ;
    endcase
  end

  a_one_per_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> state_r == S_IDLE)
    else $error("result not retired");
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall)
    else $error("request taken while busy");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_SETUP)
    else $error("load without setup");
endmodule
`default_nettype wire

### hdl/mlpq_dp.sv
// ----------------------------------------------------------------------------
// mlpq_dp: queue datapath
// Level store memory, per-level counts, level mapping and search registers.
// ----------------------------------------------------------------------------
`default_nettype none
module mlpq_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [3:0]        cfg_wdata,
  input  wire logic [1:0]        in_op,
  input  wire logic [31:0]       in_position,
  input  wire logic [7:0]        in_priority_req,
  input  wire mlpq_pkg::dp_cmd_t  cmd,
  output mlpq_pkg::dp_sts_t      sts,
  output logic [1:0]             out_status,
  output logic [31:0]            out_position,
  output logic [3:0]             out_level
);
  import mlpq_pkg::*;

  logic [3:0]      num_levels_r;
  logic [CntW-1:0] count_r [MaxLevels];
  logic [31:0]     mem [MaxLevels * LevelDepth];
  logic [31:0]     rdata_r;

  op_t             op_r;
  logic [31:0]     pos_r;
  logic [7:0]      prio_r;
  logic [LvW-1:0]  lv_r, lv_nxt;
  logic [CntW-1:0] scan_r;
  logic [CntW-1:0] shift_r;
  logic [CntW-1:0] limit_r;
  logic [1:0]      status_r;
  logic [31:0]     opos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) num_levels_r <= 4'(MaxLevels);
    else if (cfg_we) num_levels_r <= cfg_wdata;
  end

  // effective level count and priority map
  logic [3:0] eff_l, half, first;
  logic [7:0] map_lv;
  always_comb begin
    eff_l = num_levels_r;
    if (eff_l == 4'd0) eff_l = 4'd1;
    if (eff_l > 4'(MaxLevels)) eff_l = 4'(MaxLevels);
    half = 4'((5'(eff_l) + 5'd1) >> 1);
    if (half > 4'd5) half = 4'd5;
    first = 4'd5 - half;
    if (prio_r <= 8'(first)) map_lv = 8'd0;
    else begin
      map_lv = prio_r - 8'(first);
      if (map_lv > 8'(eff_l - 4'd1)) map_lv = 8'(eff_l - 4'd1);
    end
  end

  // highest non-empty level among those in use
  logic [LvW-1:0] top_lv;
  logic           top_found;
  always_comb begin
    top_lv = '0;
    top_found = 1'b0;
    for (int i = 0; i < MaxLevels; i++) begin
      if (i < int'(eff_l) && count_r[i] != '0) begin
        top_lv = LvW'(i);
        top_found = 1'b1;
      end
    end
  end

  logic [CntW-1:0] cnt;
  assign cnt = count_r[lv_r];

  always_comb begin
    lv_nxt = lv_r;
    if (cmd.set_ok) lv_nxt = (op_r == OP_CONSUME) ? top_lv : LvW'(map_lv);
  end

  logic [AddrW-1:0] base;
  assign base = AddrW'(lv_r) * AddrW'(LevelDepth);

  // memory port: one read, one write per cycle
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0]      wdata;
  logic             re;
  always_comb begin
    we    = 1'b0;
    waddr = base;
    wdata = rdata_r;
    re    = 1'b0;
    raddr = base;
    if (cmd.wr_new) begin
      we    = 1'b1;
      wdata = pos_r;
      waddr = base + AddrW'((op_r == OP_PUSH) ? cnt[IdxW-1:0] : scan_r[IdxW-1:0]);
    end
    if (cmd.wr_up || cmd.wr_dn) begin
      we    = 1'b1;
      waddr = base + AddrW'(shift_r[IdxW-1:0]);
    end
    if (cmd.rd_scan || cmd.rd_found) begin
      re = 1'b1;
      raddr = base + AddrW'(scan_r[IdxW-1:0]);
    end
    if (cmd.rd_up) begin
      re = 1'b1;
      raddr = base + AddrW'(IdxW'(shift_r - CntW'(1)));
    end
    if (cmd.rd_dn) begin
      re = 1'b1;
      raddr = base + AddrW'(IdxW'(shift_r + CntW'(1)));
    end
    if (cmd.rd_front) re = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MaxLevels; i++) count_r[i] <= '0;
    end else if (cmd.cnt_inc) begin
      count_r[lv_r] <= cnt + CntW'(1);
    end else if (cmd.cnt_dec) begin
      count_r[lv_r] <= cnt - CntW'(1);
    end
  end

  logic [31:0] dfront;
  assign dfront = pos_r - rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op_t'(in_op);
      pos_r    <= in_position;
      prio_r   <= in_priority_req;
      scan_r   <= '0;
      limit_r  <= '0;
      opos_r   <= '0;
      status_r <= ST_OK;
    end
    lv_r <= lv_nxt;
    if (cmd.set_ok) begin
      limit_r  <= count_r[lv_nxt];
      // release shifts from the tail down to the insert point
      shift_r  <= count_r[lv_nxt];
    end
    if (cmd.set_full) status_r <= ST_FULL;
    if (cmd.set_nf)   status_r <= ST_NOTFOUND;
    if (cmd.set_limit && dfront < 32'(cnt)) limit_r <= CntW'(dfront);
    if (cmd.step_scan) scan_r <= scan_r + CntW'(1);
    if (cmd.wr_up) shift_r <= shift_r - CntW'(1);
    if (cmd.wr_dn) shift_r <= shift_r + CntW'(1);
    if (cmd.set_pop) begin
      opos_r  <= rdata_r;
      shift_r <= '0;
    end
    if (cmd.rd_found) shift_r <= scan_r;
  end

  logic before_pos;
  assign before_pos = rdata_r[31:0] != pos_r && ((rdata_r - pos_r) >> 31) == 32'd1;

  always_comb begin
    sts.op           = op_r;
    sts.any_nonempty = top_found;
    sts.level_full   = count_r[lv_nxt] >= CntW'(LevelDepth);
    sts.level_empty  = count_r[lv_nxt] == '0;
    sts.scan_end     = scan_r >= limit_r;
    // advance past this entry; the next read checks the limit
    sts.scan_more    = before_pos;
    sts.up_done      = shift_r == scan_r;
    sts.dn_done      = (shift_r + CntW'(1)) >= cnt;
    sts.match        = rdata_r == pos_r;
    sts.at_in_range  = scan_r < cnt;
  end

  assign out_status   = status_r;
  assign out_position = opos_r;
  assign out_level    = 4'(lv_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> cnt < CntW'(LevelDepth))
    else $error("push into full level");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> cnt != '0)
    else $error("removal from empty level");
  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_new && (cmd.wr_up || cmd.wr_dn)))
    else $error("two store writes in one cycle");
endmodule
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the strict-priority queue unit
// Directed table then random request stream, checked against an in-bench
// model of the level stores, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import mlpq_pkg::*;

  localparam int Period = 10;
  localparam int CycleLimit = 400000;

  typedef struct {
    op_t         op;
    logic [31:0] pos;
    logic [7:0]  prio;
  } req_t;

  typedef struct {
    status_t     status;
    logic [31:0] pos;
    logic [3:0]  lvl;
  } rsp_t;

  // Directed row: request plus optional typed-in result.
  typedef struct {
    op_t         op;
    logic [31:0] pos;
    logic [7:0]  prio;
    bit          fixed;
    status_t     status;
    logic [31:0] rpos;
    logic [3:0]  rlvl;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = '0;
  logic [31:0] in_position = '0;
  logic [7:0]  in_priority_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_position;
  logic [3:0]  out_level;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;

  multi_level_priority_queue_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_position(in_position), .in_priority_req(in_priority_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_position(out_position), .out_level(out_level),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #(Period / 2) clk = ~clk;

  // Shadow queue state.
  logic [31:0] shadow_store [MaxLevels][LevelDepth];
  int          shadow_count [MaxLevels];
  logic [3:0]  shadow_levels;

  rsp_t pending_results [$];
  int   errors = 0;
  int   results_seen = 0;
  int   requests_sent = 0;
  int   cycles = 0;
  int   op_hits [4];
  int   full_hits = 0;
  int   nf_hits = 0;
  bit   stall_mode = 1'b0;

  function automatic int levels_in_use();
    int l;
    l = shadow_levels;
    if (l == 0) l = 1;
    if (l > MaxLevels) l = MaxLevels;
    return l;
  endfunction

  function automatic int level_of(logic [7:0] prio);
    int l, half, first;
    l = levels_in_use();
    half = (l + 1) / 2;
    if (half > 5) half = 5;
    first = 5 - half;
    if (prio <= first) return 0;
    if (prio - first > l - 1) return l - 1;
    return prio - first;
  endfunction

  function automatic bit serial_before(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic int first_not_before(int lv, int lim, logic [31:0] pos);
    int i;
    i = 0;
    while (i < lim && serial_before(shadow_store[lv][i], pos)) i++;
    return i;
  endfunction

  // Apply one request to the shadow state and return its result.
  function automatic rsp_t queue_apply(req_t r);
    rsp_t o;
    int lv, cnt, at, lim;
    logic [31:0] d;
    o.status = ST_OK;
    o.pos = '0;
    o.lvl = '0;
    if (r.op == OP_CONSUME) begin
      lv = -1;
      for (int i = levels_in_use() - 1; i >= 0; i--) begin
        if (lv < 0 && shadow_count[i] != 0) lv = i;
      end
      if (lv < 0) begin
        o.status = ST_NOTFOUND;
      end else begin
        o.pos = shadow_store[lv][0];
        for (int j = 1; j < shadow_count[lv]; j++)
          shadow_store[lv][j - 1] = shadow_store[lv][j];
        shadow_count[lv]--;
        o.lvl = lv;
      end
      return o;
    end
    lv = level_of(r.prio);
    o.lvl = lv;
    cnt = shadow_count[lv];
    if (r.op != OP_ERASE) begin
      if (cnt >= LevelDepth) begin
        o.status = ST_FULL;
      end else if (r.op == OP_PUSH) begin
        shadow_store[lv][cnt] = r.pos;
        shadow_count[lv]++;
      end else begin
        at = first_not_before(lv, cnt, r.pos);
        for (int j = cnt; j > at; j--) shadow_store[lv][j] = shadow_store[lv][j - 1];
        shadow_store[lv][at] = r.pos;
        shadow_count[lv]++;
      end
    end else if (cnt == 0) begin
      o.status = ST_NOTFOUND;
    end else begin
      d = r.pos - shadow_store[lv][0];
      lim = (d < cnt) ? int'(d) : cnt;
      at = first_not_before(lv, lim, r.pos);
      if (at < cnt && shadow_store[lv][at] == r.pos) begin
        for (int j = at + 1; j < cnt; j++) shadow_store[lv][j - 1] = shadow_store[lv][j];
        shadow_count[lv]--;
      end else begin
        o.status = ST_NOTFOUND;
      end
    end
    return o;
  endfunction

  // Drive one request and hold it until accepted; record its result.
  task automatic send_request(req_t r, bit fixed, rsp_t want);
    rsp_t got;
    got = queue_apply(r);
    if (fixed && (got.status != want.status || got.pos != want.pos || got.lvl != want.lvl))
      $display("%0t: table row disagrees with model: table %0d/%h/%0d model %0d/%h/%0d",
               $time, want.status, want.pos, want.lvl, got.status, got.pos, got.lvl);
    pending_results.insert(pending_results.size(), fixed ? want : got);
    op_hits[r.op]++;
    if (got.status == ST_FULL) full_hits++;
    if (got.status == ST_NOTFOUND) nf_hits++;
    in_valid <= 1'b1;
    in_op <= r.op;
    in_position <= r.pos;
    in_priority_req <= r.prio;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic go_idle(int gap);
    in_valid <= 1'b0;
    repeat (gap) @(negedge clk);
  endtask

  // Wait for every result, then let the block settle before a register write.
  task automatic drain_and_config(logic [3:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_levels = value;
  endtask

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d pos %h level %0d",
                 $time, out_status, out_position, out_level);
        errors++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          errors++;
        end
        if (out_position !== want.pos) begin
          $display("%0t: position expected %h actual %h", $time, want.pos, out_position);
          errors++;
        end
        if (out_level !== want.lvl) begin
          $display("%0t: level expected %0d actual %0d", $time, want.lvl, out_level);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern: alternate quiet stretches with random stalling.
  always @(negedge clk) begin
    if (($urandom & 63) == 0) stall_mode <= ~stall_mode;
    out_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("multi_level_priority_queue_unit test failed");
      $finish;
    end
  end

  // Random request biased toward a small pool of levels and nearby positions
  // so that erase hits, sorted inserts and full levels all happen.
  function automatic req_t random_request(logic [31:0] base);
    req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.op = (pick < 30) ? OP_PUSH : (pick < 55) ? OP_RELEASE :
           (pick < 75) ? OP_ERASE : OP_CONSUME;
    r.prio = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
    r.pos = ($urandom_range(0, 9) == 0) ? $urandom : base + $urandom_range(0, 40);
    return r;
  endfunction

  row_t table_rows [$];

  initial begin
    req_t  r;
    rsp_t  w;
    row_t  row;
    logic [31:0] base;
    int    burst;
    logic [3:0] settings [6];
    settings = '{4'd1, 4'd10, 4'd0, 4'd15, 4'd4, 4'd7};

    shadow_levels = 4'd10;
    for (int i = 0; i < MaxLevels; i++) shadow_count[i] = 0;

    // Directed table: empty consume/erase, extremes of the fields, serial wrap.
    table_rows = '{
      '{OP_CONSUME, 32'h0, 8'h00, 1, ST_NOTFOUND, 32'h0, 4'd0},
      '{OP_ERASE, 32'hFFFFFFFF, 8'hFF, 1, ST_NOTFOUND, 32'h0, 4'd9},
      '{OP_PUSH, 32'hFFFFFFFF, 8'hFF, 1, ST_OK, 32'h0, 4'd9},
      '{OP_PUSH, 32'h0, 8'h00, 1, ST_OK, 32'h0, 4'd0},
      '{OP_RELEASE, 32'h7FFFFFFF, 8'hFF, 0, ST_OK, 0, 0},
      '{OP_RELEASE, 32'h80000000, 8'hFF, 0, ST_OK, 0, 0},
      '{OP_RELEASE, 32'h00000005, 8'hFF, 0, ST_OK, 0, 0},
      '{OP_ERASE, 32'h00000005, 8'hFF, 0, ST_OK, 0, 0},
      '{OP_ERASE, 32'h12345678, 8'hFF, 0, ST_OK, 0, 0},
      '{OP_RELEASE, 32'hAAAAAAAA, 8'h55, 0, ST_OK, 0, 0},
      '{OP_RELEASE, 32'h55555555, 8'hAA, 0, ST_OK, 0, 0},
      '{OP_CONSUME, 32'hFFFFFFFF, 8'hFF, 0, ST_OK, 0, 0},
      '{OP_CONSUME, 32'h0, 8'h00, 0, ST_OK, 0, 0},
      '{OP_CONSUME, 32'h0, 8'h00, 0, ST_OK, 0, 0},
      '{OP_CONSUME, 32'h0, 8'h00, 0, ST_OK, 0, 0},
      '{OP_CONSUME, 32'h0, 8'h00, 0, ST_OK, 0, 0},
      '{OP_CONSUME, 32'h0, 8'h00, 0, ST_OK, 0, 0},
      '{OP_CONSUME, 32'h0, 8'h00, 1, ST_NOTFOUND, 32'h0, 4'd0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (table_rows[k]) begin
      row = table_rows[k];
      r = '{row.op, row.pos, row.prio};
      w = '{row.status, row.rpos, row.rlvl};
      send_request(r, row.fixed, w);
    end

    // Fill one level past its depth to reach the full case.
    for (int k = 0; k <= LevelDepth; k++) begin
      r = '{OP_PUSH, 32'(k), 8'd3};
      send_request(r, 0, w);
    end

    // Random phases, each under its own level setting.
    foreach (settings[s]) begin
      drain_and_config(settings[s]);
      base = $urandom;
      while (requests_sent < 60 + (s + 1) * 85) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst; k++) send_request(random_request(base), 0, w);
        if ($urandom_range(0, 3) == 0) go_idle($urandom_range(1, 20));
        if ($urandom_range(0, 99) == 0) base = $urandom;
      end
      // Pause until every outstanding result has come back.
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clk);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);

    $display("Ran %0d requests (push %0d, release %0d, erase %0d, consume %0d), %0d results",
             requests_sent, op_hits[0], op_hits[1], op_hits[2], op_hits[3], results_seen);
    $display("Level settings 1,10,0,15,4,7; %0d full and %0d empty/not-found outcomes",
             full_hits, nf_hits);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("multi_level_priority_queue_unit test passed");
    end else begin
      $display("multi_level_priority_queue_unit test failed");
    end
    $finish;
  end
endmodule
